FILE: src/ffha_pkg.sv
// Shared constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 24;

  localparam int FIELD_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE  = 2'd2;

endpackage

FILE: src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, header RAM and shared ALU.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_operation,              | into block
//          | in_request_bytes, in_block_offset              |
//  out     | out_valid, out_ready, out_payload_offset,      | out of block
//          | out_status                                     |
//
// An allocate walks the headers from offset 0 (one RAM read per header) and
// then splits the chosen block, hands it out whole, or reports no space; a free
// checks the offset and the header, then marks the block free, merging it with
// a free successor. The result is loaded into the output register in S_DONE.
// The single read port of the header RAM sets the walk rate. After reset the
// S_INIT state writes the initial free block at offset 0 before the first
// transfer is taken. The result sits in an output register, so a new item may
// be taken while the previous result waits; a stalled result only holds the
// sequencer once the next item has finished.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [ffha_pkg::FIELD_W-1:0]  in_request_bytes,
  input  logic [ffha_pkg::FIELD_W-1:0]  in_block_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffha_pkg::FIELD_W-1:0]  out_payload_offset,
  output logic [ffha_pkg::STATUS_W-1:0] out_status
);

  // address, size and arithmetic widths
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW + 1;
  localparam int VW = ((AW > ffha_pkg::FIELD_W) ? AW : ffha_pkg::FIELD_W) + 2;
  localparam int DW = SW + AW + 2;

  // header word layout: {size, next, has_next, is_free}
  localparam int FREE_BIT = 0;
  localparam int HAS_BIT  = 1;
  localparam int NEXT_LSB = 2;
  localparam int SIZE_LSB = NEXT_LSB + AW;

  localparam logic [VW-1:0] HEAP_V = VW'(HEAP_BYTES);
  localparam logic [VW-1:0] HDR_V  = VW'(HEADER_BYTES);
  localparam logic [SW-1:0] HEAP_S = SW'(HEAP_BYTES);
  localparam logic [SW-1:0] INIT_S = SW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [AW:0]   HEAP_N = (AW+1)'(HEAP_BYTES);
  localparam logic [AW-1:0] LAST_STEP = AW'(HEAP_BYTES - 1);

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_A_CHK = 14'b00000000000100,
    S_A_SPL = 14'b00000000001000,
    S_A_CND = 14'b00000000010000,
    S_A_WRN = 14'b00000000100000,
    S_A_WRH = 14'b00000001000000,
    S_F_RNG = 14'b00000010000000,
    S_F_HDR = 14'b00000100000000,
    S_F_MRG = 14'b00001000000000,
    S_F_SUM = 14'b00010000000000,
    S_F_SAT = 14'b00100000000000,
    S_F_WRH = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0]                 val_r, val_nxt;     // want+header, free target, merge sum
  logic [VW-1:0]                 split_r, split_nxt;
  logic [ffha_pkg::FIELD_W-1:0]  want_r, want_nxt;
  logic [AW-1:0]                 cur_r, cur_nxt;
  logic [AW-1:0]                 steps_r, steps_nxt;
  logic [DW-1:0]                 hdr_r, hdr_nxt;
  logic [SW-1:0]                 rem_r, rem_nxt;
  logic                          dosplit_r, dosplit_nxt;
  logic                          lowok_r, lowok_nxt;
  logic [AW-1:0]                 nnext_r, nnext_nxt;
  logic                          nhas_r, nhas_nxt;
  logic [ffha_pkg::FIELD_W-1:0]  res_off_r, res_off_nxt;
  logic [ffha_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ffha_pkg::FIELD_W-1:0]  out_off_r, out_off_nxt;
  logic [ffha_pkg::STATUS_W-1:0] out_st_r, out_st_nxt;

  // RAM and ALU hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [VW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_ge;

  ffha_ram #(
    .WIDTH (DW),
    .DEPTH (HEAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffha_alu #(
    .W (VW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  // fields of the freshly read header and of the held header
  logic [SW-1:0] rd_size, h_size;
  logic [AW-1:0] rd_next, h_next;
  logic          rd_has, rd_free, h_has;
  logic          rd_next_in;    // read header links to a block inside the heap
  logic          accept;
  logic          last_step;
  logic [VW-1:0] want_ext;

  assign rd_size = ram_rdata[SIZE_LSB +: SW];
  assign rd_next = ram_rdata[NEXT_LSB +: AW];
  assign rd_has  = ram_rdata[HAS_BIT];
  assign rd_free = ram_rdata[FREE_BIT];
  assign h_size  = hdr_r[SIZE_LSB +: SW];
  assign h_next  = hdr_r[NEXT_LSB +: AW];
  assign h_has   = hdr_r[HAS_BIT];

  assign rd_next_in = rd_has && ({1'b0, rd_next} < HEAP_N);
  assign last_step  = (steps_r == LAST_STEP);
  assign want_ext   = VW'(want_r);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    split_nxt     = split_r;
    want_nxt      = want_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    hdr_nxt       = hdr_r;
    rem_nxt       = rem_r;
    dosplit_nxt   = dosplit_r;
    lowok_nxt     = lowok_r;
    nnext_nxt     = nnext_r;
    nhas_nxt      = nhas_r;
    res_off_nxt   = res_off_r;
    res_st_nxt    = res_st_r;
    out_off_nxt   = out_off_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_ready;

    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = hdr_r;
    ram_raddr = '0;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // lay down the single free block covering the heap
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {INIT_S, {AW{1'b0}}, 1'b0, 1'b1};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_operation == ffha_pkg::OP_ALLOC) begin
          alu_a = VW'(in_request_bytes);
          alu_b = HDR_V;
        end else begin
          alu_a   = VW'(in_block_offset);
          alu_b   = HDR_V;
          alu_sub = 1'b1;
        end
        ram_raddr = '0;
        if (accept) begin
          val_nxt   = alu_res;
          lowok_nxt = alu_ge;
          want_nxt  = in_request_bytes;
          cur_nxt   = '0;
          steps_nxt = '0;
          state_nxt = (in_operation == ffha_pkg::OP_ALLOC) ? S_A_CHK : S_F_RNG;
        end
      end

      S_A_CHK: begin
        // one header per cycle: test fit, else follow the link or report no space
        alu_a   = VW'(rd_size);
        alu_b   = want_ext;
        hdr_nxt = ram_rdata;
        ram_raddr = rd_next;
        if (rd_free && alu_ge) begin
          state_nxt = S_A_SPL;
        end else if (!rd_next_in || last_step) begin
          res_off_nxt = '0;
          res_st_nxt  = ffha_pkg::ST_NOSPACE;
          state_nxt   = S_DONE;
        end else begin
          cur_nxt   = rd_next;
          steps_nxt = steps_r + 1'b1;
        end
      end

      S_A_SPL: begin
        alu_a     = VW'(cur_r);
        alu_b     = val_r;
        split_nxt = alu_res;
        state_nxt = S_A_CND;
      end

      S_A_CND: begin
        // split only if the remainder holds a header plus a byte, inside the heap
        alu_a       = VW'(h_size);
        alu_b       = val_r;
        alu_sub     = 1'b1;
        rem_nxt     = alu_res[SW-1:0];
        dosplit_nxt = alu_ge && (alu_res != '0) && (split_r < HEAP_V);
        state_nxt   = (alu_ge && (alu_res != '0) && (split_r < HEAP_V)) ? S_A_WRN : S_A_WRH;
      end

      S_A_WRN: begin
        ram_we    = 1'b1;
        ram_waddr = split_r[AW-1:0];
        ram_wdata = {rem_r, h_next, h_has, 1'b1};
        state_nxt = S_A_WRH;
      end

      S_A_WRH: begin
        alu_a     = VW'(cur_r);
        alu_b     = HDR_V;
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        if (dosplit_r) begin
          ram_wdata = {want_ext[SW-1:0], split_r[AW-1:0], 1'b1, 1'b0};
        end else begin
          ram_wdata = {h_size, h_next, h_has, 1'b0};
        end
        res_off_nxt = alu_res[ffha_pkg::FIELD_W-1:0];
        res_st_nxt  = ffha_pkg::ST_OK;
        state_nxt   = S_DONE;
      end

      S_F_RNG: begin
        // drop offsets below a header or beyond the heap
        alu_a       = val_r;
        alu_b       = HEAP_V;
        ram_raddr   = val_r[AW-1:0];
        cur_nxt     = val_r[AW-1:0];
        res_off_nxt = '0;
        res_st_nxt  = ffha_pkg::ST_OK;
        if (!lowok_r || alu_ge) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_F_HDR;
        end
      end

      S_F_HDR: begin
        hdr_nxt   = ram_rdata;
        ram_raddr = rd_next;
        if (rd_free) begin
          res_st_nxt = ffha_pkg::ST_DOUBLE;
          state_nxt  = S_DONE;
        end else if (rd_next_in) begin
          state_nxt = S_F_MRG;
        end else begin
          state_nxt = S_F_WRH;
        end
      end

      S_F_MRG: begin
        alu_a     = VW'(h_size);
        alu_b     = VW'(rd_size);
        val_nxt   = alu_res;
        nnext_nxt = rd_next;
        nhas_nxt  = rd_has;
        state_nxt = rd_free ? S_F_SUM : S_F_WRH;
      end

      S_F_SUM: begin
        alu_a     = val_r;
        alu_b     = HDR_V;
        val_nxt   = alu_res;
        state_nxt = S_F_SAT;
      end

      S_F_SAT: begin
        // saturate the merged size at the heap size
        alu_a     = val_r;
        alu_b     = HEAP_V;
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {(alu_ge ? HEAP_S : val_r[SW-1:0]), nnext_r, nhas_r, 1'b1};
        state_nxt = S_DONE;
      end

      S_F_WRH: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {h_size, h_next, h_has, 1'b1};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    split_r   <= split_nxt;
    want_r    <= want_nxt;
    cur_r     <= cur_nxt;
    steps_r   <= steps_nxt;
    hdr_r     <= hdr_nxt;
    rem_r     <= rem_nxt;
    dosplit_r <= dosplit_nxt;
    lowok_r   <= lowok_nxt;
    nnext_r   <= nnext_nxt;
    nhas_r    <= nhas_nxt;
    res_off_r <= res_off_nxt;
    res_st_r  <= res_st_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_payload_offset = out_off_r;
  assign out_status         = out_st_r;

`ifndef SYNTHESIS
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_A_WRN || state_r == S_A_WRH ||
                state_r == S_F_SAT || state_r == S_F_WRH))
    else $error("header write outside a write state");

  a_alloc_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == ffha_pkg::OP_ALLOC) |=> (state_r == S_A_CHK))
    else $error("allocate did not start the walk");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffha_pkg::ST_OK) |-> (out_payload_offset == '0))
    else $error("failed request reports an offset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffha_pkg::ST_OK || out_status == ffha_pkg::ST_NOSPACE ||
                   out_status == ffha_pkg::ST_DOUBLE))
    else $error("unknown status code");

  a_split_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_WRN) |-> (split_r > VW'(cur_r)))
    else $error("split header not above its block");
`endif

endmodule

FILE: src/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ffha_alu.sv
// Shared add/subtract and compare unit used by the allocator sequencer.
module ffha_alu #(
  parameter int W = 12
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge
);

  // one adder serves both directions: invert b and carry in for subtract
  assign res = a + (sub ? ~b : b) + {{(W-1){1'b0}}, sub};
  assign ge  = (a >= b);

endmodule
